>>> hdl/pei_pkg.sv
// ----------------------------------------------------------------------------
// pei_pkg
// Shared types, word map and defaults for the pin edge interrupt controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pei_pkg;

    localparam int ADDR_W = 8;
    localparam int DATA_W = 32;
    localparam int PIN_W  = 8;
    localparam int DMA_W  = 4;

    localparam int WINDOW_WORDS_DEF = 16;
    localparam int CHANNELS_DEF     = 8;
    localparam int DMA_LINES_DEF    = 4;

    // item kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_PINS  = 2'd2;

    // word map
    localparam logic [ADDR_W-1:0] W_MODE       = 8'd0;
    localparam logic [ADDR_W-1:0] W_IEN_RISE   = 8'd1;
    localparam logic [ADDR_W-1:0] W_SET_RISE   = 8'd2;
    localparam logic [ADDR_W-1:0] W_CLR_RISE   = 8'd3;
    localparam logic [ADDR_W-1:0] W_IEN_FALL   = 8'd4;
    localparam logic [ADDR_W-1:0] W_SET_FALL   = 8'd5;
    localparam logic [ADDR_W-1:0] W_CLR_FALL   = 8'd6;
    localparam logic [ADDR_W-1:0] W_RISE       = 8'd7;
    localparam logic [ADDR_W-1:0] W_FALL       = 8'd8;
    localparam logic [ADDR_W-1:0] W_STATUS     = 8'd9;
    localparam logic [ADDR_W-1:0] W_PLAIN_BASE = 8'd10;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [PIN_W-1:0]  levels;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic [DMA_W-1:0]  dma;
        logic              oow;
    } t_result;

endpackage

>>> hdl/pin_edge_interrupt_controller_unit.sv
// ----------------------------------------------------------------------------
// pin_edge_interrupt_controller_unit
// Eight-channel pin edge interrupt block with a small bus register window.
// The input register loads on accept and the result register when the item
// moves on from it, which an output stall can hold back.
// Throughput: one item per cycle; the input register and result register
// form a two-entry pipeline, so input ready only drops on output stall.
// Reset (i_rst_n low, synchronous): flags, enables, mode, previous levels
// and plain-word valid bits cleared; plain words read zero until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pin_edge_interrupt_controller_unit #(
    parameter int WINDOW_WORDS = pei_pkg::WINDOW_WORDS_DEF,
    parameter int CHANNELS     = pei_pkg::CHANNELS_DEF,
    parameter int DMA_LINES    = pei_pkg::DMA_LINES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_kind,
    input  logic [pei_pkg::ADDR_W-1:0]    i_word_address,
    input  logic [pei_pkg::DATA_W-1:0]    i_write_data,
    input  logic [pei_pkg::PIN_W-1:0]     i_pin_levels,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pei_pkg::DATA_W-1:0]    o_read_data,
    output logic                          o_irq,
    output logic [pei_pkg::DMA_W-1:0]     o_dma_pulse,
    output logic                          o_out_of_window
);

    pei_pkg::t_item             in_item;
    pei_pkg::t_item             r_s1;
    logic                       r_s1_vld;
    pei_pkg::t_result           w_res;
    pei_pkg::t_result           r_res;
    logic                       r_out_vld;
    logic                       in_acc;
    logic                       s1_move;
    logic [pei_pkg::DATA_W-1:0] plain_rd;

    assign in_item.kind   = i_kind;
    assign in_item.addr   = i_word_address;
    assign in_item.data   = i_write_data;
    assign in_item.levels = i_pin_levels;

    assign s1_move    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    pei_plain_mem #(
        .WINDOW_WORDS (WINDOW_WORDS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (in_acc),
        .i_item    (in_item),
        .o_rd_data (plain_rd)
    );

    pei_ctrl_regs #(
        .WINDOW_WORDS (WINDOW_WORDS),
        .CHANNELS     (CHANNELS),
        .DMA_LINES    (DMA_LINES)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (s1_move),
        .i_item     (r_s1),
        .i_plain_rd (plain_rd),
        .o_result   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= in_acc || (r_s1_vld && !s1_move);
            r_out_vld <= s1_move || (r_out_vld && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= in_item;
        end
        if (s1_move) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_read_data     = r_res.read_data;
    assign o_irq           = r_res.irq;
    assign o_dma_pulse     = r_res.dma;
    assign o_out_of_window = r_res.oow;

`ifndef SYNTHESIS
    // a stalled item in the input register is held unchanged
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_move |=> r_s1_vld && $stable(r_s1))
        else $error("input stage item lost or changed while stalled");

    // dma only fires for pin vectors
    a_dma_pins_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && (r_s1.kind != pei_pkg::KIND_PINS) |-> (w_res.dma == '0))
        else $error("dma pulse on a bus item");

    // out-of-window accesses return zero
    a_oow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && w_res.oow |-> (w_res.read_data == '0))
        else $error("out-of-window access returned data");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

>>> hdl/pei_plain_mem.sv
// ----------------------------------------------------------------------------
// pei_plain_mem
// Plain storage words above the control block; per-entry valid bits give
// zero until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pei_plain_mem #(
    parameter int WINDOW_WORDS = pei_pkg::WINDOW_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_acc,
    input  pei_pkg::t_item              i_item,
    output logic [pei_pkg::DATA_W-1:0]  o_rd_data
);

    localparam int PLAIN_WORDS = WINDOW_WORDS - 10;
    localparam int PW_AW = (PLAIN_WORDS > 1) ? $clog2(PLAIN_WORDS) : 1;
    localparam logic [pei_pkg::ADDR_W:0] WIN_END = (pei_pkg::ADDR_W + 1)'(WINDOW_WORDS);

    logic [pei_pkg::DATA_W-1:0] mem [PLAIN_WORDS];
    logic [PLAIN_WORDS-1:0]     r_vld;
    logic [pei_pkg::DATA_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    logic                        hit;
    logic                        wr;
    logic                        rd;
    logic [pei_pkg::ADDR_W-1:0]  offs;
    logic [PW_AW-1:0]            idx;

    assign hit  = (i_item.addr >= pei_pkg::W_PLAIN_BASE) && ({1'b0, i_item.addr} < WIN_END);
    assign wr   = i_acc && (i_item.kind == pei_pkg::KIND_WRITE) && hit;
    assign rd   = i_acc && (i_item.kind == pei_pkg::KIND_READ) && hit;
    assign offs = i_item.addr - pei_pkg::W_PLAIN_BASE;
    assign idx  = offs[PW_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[idx] <= i_item.data;
        end
        if (rd) begin
            r_rd_data <= mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr) begin
                r_vld[idx] <= 1'b1;
            end
            if (rd) begin
                r_rd_vld <= r_vld[idx];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

>>> hdl/pei_ctrl_regs.sv
// ----------------------------------------------------------------------------
// pei_ctrl_regs
// Control and flag words, edge detect and result formation for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pei_ctrl_regs #(
    parameter int WINDOW_WORDS = pei_pkg::WINDOW_WORDS_DEF,
    parameter int CHANNELS     = pei_pkg::CHANNELS_DEF,
    parameter int DMA_LINES    = pei_pkg::DMA_LINES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_commit,
    input  pei_pkg::t_item              i_item,
    input  logic [pei_pkg::DATA_W-1:0]  i_plain_rd,
    output pei_pkg::t_result            o_result
);

    localparam int DMA_EFF = (DMA_LINES > pei_pkg::DMA_W) ? pei_pkg::DMA_W : DMA_LINES;
    localparam logic [pei_pkg::DMA_W-1:0] DMA_MASK = pei_pkg::DMA_W'((1 << DMA_EFF) - 1);
    localparam logic [pei_pkg::PIN_W-1:0] CHAN_MASK = pei_pkg::PIN_W'((1 << CHANNELS) - 1);
    localparam logic [pei_pkg::ADDR_W:0]  WIN_END = (pei_pkg::ADDR_W + 1)'(WINDOW_WORDS);
    localparam int PAD = pei_pkg::DATA_W - pei_pkg::PIN_W;

    logic [pei_pkg::DATA_W-1:0] r_mode, r_ien_rise, r_ien_fall, r_rise, r_fall, r_status;
    logic [pei_pkg::DATA_W-1:0] n_mode, n_ien_rise, n_ien_fall, n_rise, n_fall, n_status;
    logic [pei_pkg::PIN_W-1:0]  r_prev, n_prev;

    logic                       in_win;
    logic                       is_bus;
    logic [pei_pkg::PIN_W-1:0]  edge_ok;
    logic [pei_pkg::PIN_W-1:0]  rise;
    logic [pei_pkg::PIN_W-1:0]  fall;
    logic [pei_pkg::PIN_W-1:0]  fired;
    logic [pei_pkg::DATA_W-1:0] rd_word;

    assign in_win  = {1'b0, i_item.addr} < WIN_END;
    assign is_bus  = (i_item.kind == pei_pkg::KIND_READ) || (i_item.kind == pei_pkg::KIND_WRITE);
    assign edge_ok = ~r_mode[pei_pkg::PIN_W-1:0] & CHAN_MASK;
    assign rise    = i_item.levels & ~r_prev & r_ien_rise[pei_pkg::PIN_W-1:0] & edge_ok;
    assign fall    = ~i_item.levels & r_prev & r_ien_fall[pei_pkg::PIN_W-1:0] & edge_ok;
    assign fired   = rise | fall;

    // bus read mux; aliases read as zero
    always_comb begin
        case (i_item.addr)
            pei_pkg::W_MODE:     rd_word = r_mode;
            pei_pkg::W_IEN_RISE: rd_word = r_ien_rise;
            pei_pkg::W_IEN_FALL: rd_word = r_ien_fall;
            pei_pkg::W_RISE:     rd_word = r_rise;
            pei_pkg::W_FALL:     rd_word = r_fall;
            pei_pkg::W_STATUS:   rd_word = r_status;
            pei_pkg::W_SET_RISE, pei_pkg::W_CLR_RISE,
            pei_pkg::W_SET_FALL, pei_pkg::W_CLR_FALL: rd_word = '0;
            default:             rd_word = i_plain_rd;
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_ien_rise = r_ien_rise;
        n_ien_fall = r_ien_fall;
        n_rise     = r_rise;
        n_fall     = r_fall;
        n_status   = r_status;
        n_prev     = r_prev;
        if (i_item.kind == pei_pkg::KIND_WRITE && in_win) begin
            case (i_item.addr)
                pei_pkg::W_MODE:     n_mode     = i_item.data;
                pei_pkg::W_IEN_RISE: n_ien_rise = i_item.data;
                pei_pkg::W_SET_RISE: n_ien_rise = r_ien_rise | i_item.data;
                pei_pkg::W_CLR_RISE: n_ien_rise = r_ien_rise & ~i_item.data;
                pei_pkg::W_IEN_FALL: n_ien_fall = i_item.data;
                pei_pkg::W_SET_FALL: n_ien_fall = r_ien_fall | i_item.data;
                pei_pkg::W_CLR_FALL: n_ien_fall = r_ien_fall & ~i_item.data;
                pei_pkg::W_RISE:     n_rise     = r_rise & ~i_item.data;
                pei_pkg::W_FALL:     n_fall     = r_fall & ~i_item.data;
                pei_pkg::W_STATUS:   n_status   = r_status & ~i_item.data;
                default:             n_mode     = r_mode; // plain storage lives in memory
            endcase
        end else if (i_item.kind == pei_pkg::KIND_PINS) begin
            n_rise   = r_rise | {{PAD{1'b0}}, rise};
            n_fall   = r_fall | {{PAD{1'b0}}, fall};
            n_status = r_status | {{PAD{1'b0}}, fired};
            n_prev   = i_item.levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_ien_rise <= '0;
            r_ien_fall <= '0;
            r_rise     <= '0;
            r_fall     <= '0;
            r_status   <= '0;
            r_prev     <= '0;
        end else if (i_commit) begin
            r_mode     <= n_mode;
            r_ien_rise <= n_ien_rise;
            r_ien_fall <= n_ien_fall;
            r_rise     <= n_rise;
            r_fall     <= n_fall;
            r_status   <= n_status;
            r_prev     <= n_prev;
        end
    end

    always_comb begin
        o_result.read_data = (i_item.kind == pei_pkg::KIND_READ && in_win) ? rd_word : '0;
        o_result.irq       = |n_status[pei_pkg::PIN_W-1:0];
        o_result.dma       = (i_item.kind == pei_pkg::KIND_PINS) ?
                             (fired[pei_pkg::DMA_W-1:0] & DMA_MASK) : '0;
        o_result.oow       = is_bus && !in_win;
    end

endmodule
